### sv/mexp_pkg.sv
// Shared widths, constants and controller state encoding for the modular exponentiation unit.
package mexp_pkg;

    localparam int FIELD_W = 63;   // base and exponent width
    localparam int WORD_W  = 32;   // modulus and result width
    localparam int CNT_W   = 6;    // bit counter, covers FIELD_W - 1

    localparam logic [WORD_W-1:0] MODULUS_RESET = 32'd1000000007;
    localparam logic [CNT_W-1:0]  REDUCE_LAST   = 6'(FIELD_W - 1);
    localparam logic [CNT_W-1:0]  MUL_LAST      = 6'(WORD_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_BIT    = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_SQUARE = 5'b10000
    } state_t;

endpackage

### sv/modular_exponentiation_unit.sv
// Top level: bit-serial right-to-left square-and-multiply modular exponentiation.
// Sequence: the base is reduced bit by bit first; then per set exponent bit a decision, a multiply
//   and a further decision, and per bit below the highest a squaring (plus a decision for a
//   clear bit).
// Throughput: one request at a time; the shared 32-step shift-add modular multiplier sets the pace.
// Reset: synchronous, active-low aresetn; clears controller and output valid, modulus 1000000007.
module modular_exponentiation_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // modulus write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   cfg_modulus,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mexp_pkg::FIELD_W-1:0]  s_base,
    input  logic [mexp_pkg::FIELD_W-1:0]  s_exponent,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mexp_pkg::WORD_W-1:0]   m_result
);
    import mexp_pkg::*;

    state_t state_reg, state_next;

    logic [WORD_W-1:0]  mod_reg;        // configured modulus, zero stands for 2^32
    logic [FIELD_W-1:0] base_sh_reg;    // base, shifted out MSB first during reduction
    logic [FIELD_W-1:0] exp_reg;        // exponent, consumed LSB first
    logic [WORD_W-1:0]  red_reg;        // partial remainder of the base
    logic [WORD_W-1:0]  pow_reg;        // current power of the base
    logic [WORD_W-1:0]  acc_reg;        // running result
    logic [WORD_W-1:0]  ma_reg;         // multiplicand, held for the whole multiply
    logic [WORD_W-1:0]  mb_reg;         // multiplier, shifted out MSB first
    logic [WORD_W-1:0]  mr_reg;         // multiply partial result, always below the modulus
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;

    // Effective modulus: a zero register means 2^32, so every reduction wraps at 32 bits.
    logic [WORD_W:0] m_eff;
    assign m_eff = (mod_reg == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, mod_reg};

    // Base reduction step: shift in one base bit, subtract the modulus once if it fits.
    logic [WORD_W:0]   red_s;
    logic [WORD_W+1:0] red_d;
    logic [WORD_W-1:0] red_step;
    assign red_s    = {red_reg, base_sh_reg[FIELD_W-1]};
    assign red_d    = {1'b0, red_s} - {1'b0, m_eff};
    assign red_step = red_d[WORD_W+1] ? red_s[WORD_W-1:0] : red_d[WORD_W-1:0];

    // Interleaved modular multiply step: r = 2r + bit*a, below 3m, then drop m or 2m.
    logic [WORD_W+1:0] mul_s;
    logic [WORD_W+2:0] mul_d1, mul_d2;
    logic [WORD_W-1:0] mul_step;
    assign mul_s  = {1'b0, mr_reg, 1'b0}
                  + {2'b00, (mb_reg[WORD_W-1] ? ma_reg : {WORD_W{1'b0}})};
    assign mul_d1 = {1'b0, mul_s} - {2'b00, m_eff};
    assign mul_d2 = {1'b0, mul_s} - {1'b0, m_eff, 1'b0};

    always_comb begin
        if (!mul_d2[WORD_W+2]) begin
            mul_step = mul_d2[WORD_W-1:0];
        end else if (!mul_d1[WORD_W+2]) begin
            mul_step = mul_d1[WORD_W-1:0];
        end else begin
            mul_step = mul_s[WORD_W-1:0];
        end
    end

    logic cnt_done;
    logic out_free;
    assign cnt_done = (cnt_reg == '0);
    assign out_free = !out_valid_reg || m_ready;

    // Controller: reduce the base, then walk the exponent one bit at a time, LSB first.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (cnt_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (exp_reg == '0) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (exp_reg[0]) begin
                    state_next = ST_MUL;
                end else if (exp_reg[FIELD_W-1:1] != '0) begin
                    state_next = ST_SQUARE;
                end else begin
                    state_next = ST_BIT;
                end
            end
            ST_MUL: begin
                if (cnt_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_SQUARE: begin
                if (cnt_done) begin
                    state_next = ST_BIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MODULUS_RESET;
        end else begin
            state_reg <= state_next;
            // Config writes must arrive only while idle (the block does not enforce it); take them at once.
            if (cfg_valid) begin
                mod_reg <= cfg_modulus;
            end
            // Drop the result once taken; a new one may land in the same cycle below.
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_BIT && exp_reg == '0 && out_free) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_sh_reg <= s_base;
                    exp_reg     <= s_exponent;
                    red_reg     <= '0;
                    acc_reg     <= {{(WORD_W-1){1'b0}}, 1'b1};
                    cnt_reg     <= REDUCE_LAST;
                end
            end
            ST_REDUCE: begin
                red_reg     <= red_step;
                base_sh_reg <= {base_sh_reg[FIELD_W-2:0], 1'b0};
                cnt_reg     <= cnt_reg - 1'b1;
                if (cnt_done) begin
                    pow_reg <= red_step;
                end
            end
            ST_BIT: begin
                if (exp_reg == '0) begin
                    if (out_free) begin
                        result_reg <= acc_reg;
                    end
                end else if (exp_reg[0]) begin
                    // Multiply the running result by the power; retire the bit.
                    ma_reg     <= pow_reg;
                    mb_reg     <= acc_reg;
                    mr_reg     <= '0;
                    cnt_reg    <= MUL_LAST;
                    exp_reg[0] <= 1'b0;
                end else begin
                    // Advance to the next bit; square only if bits remain.
                    exp_reg <= {1'b0, exp_reg[FIELD_W-1:1]};
                    ma_reg  <= pow_reg;
                    mb_reg  <= pow_reg;
                    mr_reg  <= '0;
                    cnt_reg <= MUL_LAST;
                end
            end
            ST_MUL: begin
                mr_reg  <= mul_step;
                mb_reg  <= {mb_reg[WORD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_done) begin
                    acc_reg <= mul_step;
                end
            end
            ST_SQUARE: begin
                mr_reg  <= mul_step;
                mb_reg  <= {mb_reg[WORD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_done) begin
                    pow_reg <= mul_step;
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_result  = result_reg;

endmodule

### tb/sv/mexp_checker.sv
`timescale 1ns / 100ps
// Watches the request, result and modulus channels, predicts each power and compares results.
module mexp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   cfg_modulus,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [mexp_pkg::FIELD_W-1:0]  s_base,
    input  logic [mexp_pkg::FIELD_W-1:0]  s_exponent,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   m_result,
    output int                            mismatches,
    output int                            outstanding
);
    import mexp_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [WORD_W-1:0]  modulus;
        logic [WORD_W-1:0]  power;
    } power_entry_t;

    power_entry_t       owed_powers[$];
    logic [WORD_W-1:0]  modulus_copy;

    // Right-to-left square-and-multiply; a zero modulus stands for 2^32.
    function automatic logic [WORD_W-1:0] mod_power(logic [FIELD_W-1:0] base,
                                                    logic [FIELD_W-1:0] exponent,
                                                    logic [WORD_W-1:0]  modulus);
        logic [63:0]        m;
        logic [63:0]        sq;
        logic [63:0]        acc;
        logic [FIELD_W-1:0] e;
        m   = (modulus == '0) ? 64'h1_0000_0000 : {32'd0, modulus};
        sq  = {1'b0, base} % m;
        acc = 64'd1;
        e   = exponent;
        while (e != '0) begin
            if (e[0])
                acc = (acc * sq) % m;
            e  = e >> 1;
            sq = (sq * sq) % m;
        end
        return acc[WORD_W-1:0];
    endfunction

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        power_entry_t req;
        power_entry_t owed;
        if (!aresetn) begin
            modulus_copy = MODULUS_RESET;
            owed_powers.delete();
        end else begin
            if (s_valid && s_ready) begin
                req.base     = s_base;
                req.exponent = s_exponent;
                req.modulus  = modulus_copy;
                req.power    = mod_power(s_base, s_exponent, modulus_copy);
                owed_powers.insert(owed_powers.size(), req);
            end
            if (m_valid && m_ready) begin
                if (owed_powers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result %h", $realtime, m_result);
                end else begin
                    owed = owed_powers.pop_front();
                    if (m_result !== owed.power) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result mismatch: base %h exp %h mod %h exp'd %h got %h",
                                     $realtime, owed.base, owed.exponent, owed.modulus,
                                     owed.power, m_result);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                modulus_copy = cfg_modulus;
        end
        outstanding = owed_powers.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
module testbench;
    import mexp_pkg::*;

    localparam logic [FIELD_W-1:0] FIELD_MAX   = '1;
    localparam logic [WORD_W-1:0]  WORD_MAX    = '1;
    localparam int                 CYCLE_LIMIT = 3_000_000;
    localparam int                 PHASE_ITEMS = 24;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WORD_W-1:0]  cfg_modulus;
    logic               s_valid;
    logic               s_ready;
    logic [FIELD_W-1:0] s_base;
    logic [FIELD_W-1:0] s_exponent;
    logic               m_valid;
    logic               m_ready;
    logic [WORD_W-1:0]  m_result;

    int                 mismatches;
    int                 outstanding;
    int                 cycles;
    logic [WORD_W-1:0]  modulus_now;
    bit                 s_quiet;
    bit                 m_quiet;

    modular_exponentiation_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_modulus (cfg_modulus),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    mexp_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_modulus (cfg_modulus),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock: low half, then high half.
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: a correct run ends far below this.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Draw a random wait, zero while quiet; a quiet stretch forces back-to-back traffic.
    function automatic int draw_wait(ref bit quiet);
        if ($urandom_range(0, 11) == 0)
            quiet = !quiet;
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        return FIELD_W'({$urandom(), $urandom()});
    endfunction

    // Result side: stall a random number of cycles before each result, then hold ready
    // until it is taken.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall   = draw_wait(m_quiet);
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Offer one request after a random gap; hold valid and payload until accepted.
    // Leaves valid high on return so a zero gap next time keeps the channel busy.
    task automatic push_request(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
        int gap;
        gap = draw_wait(s_quiet);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_base     = b;
        s_exponent = e;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_requests();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write the modulus while the unit is idle.
    task automatic write_modulus(input logic [WORD_W-1:0] value);
        drain_requests();
        cfg_valid   = 1'b1;
        cfg_modulus = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid   = 1'b0;
        modulus_now = value;
    endtask

    // Mostly short exponents keep the run fast; a share of full-width ones reach the top bits.
    task automatic push_random();
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        int                 pick;
        int                 w;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            e = rand_field();
        else if (pick < 25)
            e = FIELD_W'($urandom_range(0, 3));
        else begin
            w = $urandom_range(1, 16);
            e = rand_field() & ((FIELD_W'(1) << w) - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            b = rand_field();
        else if (pick < 75)
            b = FIELD_W'($urandom_range(0, 1000));
        else if (pick < 88)
            b = FIELD_W'(modulus_now) * FIELD_W'($urandom_range(0, 4));
        else
            b = FIELD_W'(modulus_now) - 1;
        push_request(b, e);
    endtask

    initial begin
        logic [WORD_W-1:0] phase_moduli[5];
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_modulus = '0;
        s_valid     = 1'b0;
        s_base      = '0;
        s_exponent  = '0;
        s_quiet     = 1'b0;
        m_quiet     = 1'b0;
        modulus_now = MODULUS_RESET;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: reset modulus, zero exponent (including zero to the zero), field extremes,
        // base equal to the modulus.
        push_request('0, '0);
        push_request(FIELD_MAX, '0);
        push_request('0, 63'd5);
        push_request(FIELD_MAX, FIELD_MAX);
        push_request(63'd1, FIELD_MAX);
        push_request(63'd2, 63'd10);
        push_request(63'(MODULUS_RESET), 63'd3);
        push_request(63'(MODULUS_RESET) - 1, 63'd2);
        push_request(rand_field(), 63'd1);

        // Modulus of one: zero exponent still yields one, anything else zero.
        write_modulus(32'd1);
        push_request(63'd5, '0);
        push_request(63'd5, 63'd1);
        push_request(FIELD_MAX, FIELD_MAX);

        // Zero modulus wraps all arithmetic at 2^32.
        write_modulus('0);
        push_request(FIELD_MAX, 63'd1);
        push_request(63'd3, FIELD_MAX);
        push_request(63'(WORD_MAX), 63'd2);

        // Largest modulus.
        write_modulus(WORD_MAX);
        push_request(FIELD_MAX, FIELD_MAX);
        push_request(63'(WORD_MAX) - 1, 63'd3);
        push_request(63'(WORD_MAX), 63'd1);

        write_modulus(32'd2);
        push_request(63'd3, FIELD_MAX);
        push_request(63'd4, 63'd1);

        // Random phases, each under its own modulus; one pause mid-phase lets the pipe empty.
        phase_moduli[0] = $urandom();
        phase_moduli[1] = $urandom_range(1, 1000);
        phase_moduli[2] = 32'hFFFF_FFFB;
        phase_moduli[3] = MODULUS_RESET;
        phase_moduli[4] = $urandom();
        foreach (phase_moduli[p]) begin
            write_modulus(phase_moduli[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain_requests();
                push_random();
            end
        end

        // Let the last results come home, then a short tail for strays.
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### modular_exponentiation_unit.f
sv/mexp_pkg.sv
sv/modular_exponentiation_unit.sv
tb/sv/mexp_checker.sv
tb/sv/testbench.sv
